// ===== sv/nud_pkg.sv =====
`default_nettype none
package nud_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int LEN_OUT_W   = 24;
  localparam logic [4:0] TYPE_MASK = 5'h1f;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'h01;
  localparam logic [7:0] BYTE_EPB   = 8'h03;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef struct packed {
    logic [1:0]           zeros;
    logic                 byte_en;
    logic [7:0]           data;
    logic                 end_en;
    logic                 hdr;
    logic [4:0]           ntype;
    logic [1:0]           ref_idc;
    logic [LEN_OUT_W-1:0] len;
  } nud_work_t;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           data;
    logic                 hdr;
    logic [4:0]           ntype;
    logic [1:0]           ref_idc;
    logic [LEN_OUT_W-1:0] len;
    logic                 last;
  } nud_result_t;

  function automatic logic [LEN_OUT_W-1:0] len_out(input logic [LENGTH_BITS-1:0] cnt);
    logic [LENGTH_BITS+LEN_OUT_W-1:0] ext;
    ext = (LENGTH_BITS + LEN_OUT_W)'(cnt);
    return ext[LEN_OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/h264_nal_unit_deframer.sv =====
// An accepted byte is registered in the work register; its results then pass
// through the single result register. Throughput: one input byte or one result
// per cycle while the output is not stalled; a byte that releases held zeros
// yields up to four results and holds input until the last is issued.
// Reset: synchronous, active low; clears the parser state and both valid flags.
`default_nettype none
module h264_nal_unit_deframer
  import nud_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  wire logic        in_tlast,   // end_of_stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] payload_byte, [8] header_flag,
                                       // [13:9] nal_unit_type, [15:14] nal_ref_idc,
                                       // [39:16] unit_length
  output logic             out_tuser,  // kind
  output logic             out_tlast   // last
);

  nud_work_t   work;
  logic        work_valid;
  logic        work_ready;
  nud_result_t result;
  logic        accept;

  assign in_tready = work_ready;
  assign accept    = in_tvalid && work_ready;

  nud_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .stream_byte  (in_tdata),
    .end_of_stream(in_tlast),
    .accept       (accept),
    .work         (work),
    .work_valid   (work_valid)
  );

  nud_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .work         (work),
    .work_valid   (work_valid),
    .work_ready   (work_ready),
    .result       (result),
    .result_valid (out_tvalid),
    .result_ready (out_tready)
  );

  assign out_tdata = {result.len, result.ref_idc, result.ntype, result.hdr, result.data};
  assign out_tuser = result.kind;
  assign out_tlast = result.last;

endmodule
`default_nettype wire

// ===== sv/nud_decode.sv =====
`default_nettype none
module nud_decode
  import nud_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] stream_byte,
  input  wire logic       end_of_stream,
  input  wire logic       accept,
  output nud_work_t       work,
  output logic            work_valid
);

  logic [1:0]             pz_r, pz_nxt;
  logic                   in_unit_r, in_unit_nxt;
  logic                   exp_hdr_r, exp_hdr_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic [4:0]             type_r, type_nxt;
  logic [1:0]             ref_r, ref_nxt;

  logic [2:0]             n_emit;
  logic [LENGTH_BITS:0]   count_sum;
  logic [7:0]             hdr_byte;

  always_comb begin
    pz_nxt      = pz_r;
    in_unit_nxt = in_unit_r;
    exp_hdr_nxt = exp_hdr_r;
    count_nxt   = count_r;
    type_nxt    = type_r;
    ref_nxt     = ref_r;
    work        = '0;
    work.ntype  = type_r;
    work.ref_idc = ref_r;
    work.len    = len_out(count_r);
    n_emit      = 3'd0;
    count_sum   = '0;
    hdr_byte    = BYTE_ZERO;
    if (end_of_stream) begin
      work.end_en = in_unit_r && !exp_hdr_r;
      in_unit_nxt = 1'b0;
      exp_hdr_nxt = 1'b0;
      pz_nxt      = 2'd0;
    end else if (stream_byte == BYTE_ZERO) begin
      pz_nxt = (pz_r == 2'd3) ? 2'd3 : pz_r + 2'd1;
    end else if (stream_byte == BYTE_START && pz_r >= 2'd2) begin
      work.end_en = in_unit_r && !exp_hdr_r;
      in_unit_nxt = 1'b1;
      exp_hdr_nxt = 1'b1;
      count_nxt   = '0;
      pz_nxt      = 2'd0;
    end else begin
      if (in_unit_r) begin
        work.zeros   = pz_r;
        work.byte_en = !(stream_byte == BYTE_EPB && pz_r >= 2'd2);
        work.data    = stream_byte;
        n_emit       = {1'b0, pz_r} + {2'b00, work.byte_en};
        hdr_byte     = (pz_r != 2'd0) ? BYTE_ZERO : stream_byte;
        if (exp_hdr_r) begin
          work.hdr     = 1'b1;
          type_nxt     = hdr_byte[4:0] & TYPE_MASK;
          ref_nxt      = hdr_byte[6:5];
          work.ntype   = type_nxt;
          work.ref_idc = ref_nxt;
          exp_hdr_nxt  = 1'b0;
        end
        count_sum = (LENGTH_BITS + 1)'(count_r) + (LENGTH_BITS + 1)'(n_emit);
        count_nxt = count_sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}}
                                           : count_sum[LENGTH_BITS-1:0];
      end
      pz_nxt = 2'd0;
    end
    work_valid = accept && (work.end_en || work.byte_en || work.zeros != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pz_r      <= 2'd0;
      in_unit_r <= 1'b0;
      exp_hdr_r <= 1'b0;
      count_r   <= '0;
      type_r    <= 5'd0;
      ref_r     <= 2'd0;
    end else if (accept) begin
      pz_r      <= pz_nxt;
      in_unit_r <= in_unit_nxt;
      exp_hdr_r <= exp_hdr_nxt;
      count_r   <= count_nxt;
      type_r    <= type_nxt;
      ref_r     <= ref_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/nud_emit.sv =====
`default_nettype none
module nud_emit
  import nud_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire nud_work_t work,
  input  wire logic  work_valid,
  output logic       work_ready,
  output nud_result_t result,
  output logic       result_valid,
  input  wire logic  result_ready
);

  nud_work_t   work_r;
  logic        busy_r;
  nud_result_t res_r;
  logic        res_valid_r;
  nud_result_t res_nxt;
  logic        out_free;
  logic        fire;

  always_comb begin
    res_nxt         = '0;
    res_nxt.ntype   = work_r.ntype;
    res_nxt.ref_idc = work_r.ref_idc;
    if (work_r.end_en) begin
      res_nxt.kind = KIND_END;
      res_nxt.len  = work_r.len;
      res_nxt.last = 1'b1;
    end else if (work_r.zeros != 2'd0) begin
      res_nxt.kind = KIND_PAYLOAD;
      res_nxt.data = BYTE_ZERO;
      res_nxt.hdr  = work_r.hdr;
      res_nxt.last = (work_r.zeros == 2'd1) && !work_r.byte_en;
    end else begin
      res_nxt.kind = KIND_PAYLOAD;
      res_nxt.data = work_r.data;
      res_nxt.hdr  = work_r.hdr;
      res_nxt.last = 1'b1;
    end
  end

  assign out_free   = !res_valid_r || result_ready;
  assign fire       = busy_r && out_free;
  assign work_ready = !busy_r || (fire && res_nxt.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (work_valid && work_ready) begin
      busy_r <= 1'b1;
    end else if (fire && res_nxt.last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work_valid && work_ready) begin
      work_r <= work;
    end else if (fire) begin
      work_r.zeros <= work_r.zeros - 2'd1;
      work_r.hdr   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (fire) begin
      res_valid_r <= 1'b1;
    end else if (result_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign result       = res_r;
  assign result_valid = res_valid_r;

endmodule
`default_nettype wire
